// ----- rtl/core/rmsp_pkg.sv -----
// Shared types and constants for the RMSprop weight update block.
// Used by the square root and divider pipelines and by the top level.
// Depends on nothing.
package rmsp_pkg;

	// Field widths.
	localparam int DATA_W = 32;
	localparam int IDX_W  = 12;
	localparam int CFG_W  = 16;
	localparam int V_W    = 48;
	localparam int ROOT_W = 24;
	localparam int DEN_W  = ROOT_W + 1;
	localparam int NUM_W  = CFG_W + DATA_W;
	localparam int TAG_W  = 8;

	// Square root pipeline: two result bits per stage.
	localparam int SQ_STEPS  = 2;
	localparam int SQ_STAGES = ROOT_W / SQ_STEPS;
	localparam int SQ_REM_W  = ROOT_W + 3;

	// Divider pipeline: four quotient bits per stage.
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = NUM_W / DIV_STEPS;
	localparam int DIV_REM_W  = DEN_W + 1;

	// Configuration register indexes and reset values.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] REG_LR    = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY = 1'b1;
	localparam logic [CFG_W-1:0] LR_RESET    = 16'd66;
	localparam logic [CFG_W-1:0] DECAY_RESET = 16'd58982;

	// Command codes of an input item.
	typedef enum logic {
		CMD_UPDATE = 1'b0,
		CMD_CLEAR  = 1'b1
	} cmd_t;

	// Per-item context that travels along the arithmetic pipelines.
	typedef struct packed {
		cmd_t              cmd;
		logic [IDX_W-1:0]  idx;
		logic [DATA_W-1:0] weight;
		logic              neg;
		logic [DATA_W-1:0] mag;
	} ctx_t;

endpackage

// ----- rtl/core/rmsp_sqrt.sv -----
// Pipelined integer square root, floor(sqrt(rad)), two result bits per stage.
// Carries the item context alongside. Depends on rmsp_pkg.
module rmsp_sqrt
	import rmsp_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic              in_valid,
	input  logic [V_W-1:0]    in_rad,
	input  ctx_t              in_ctx,
	output logic              out_valid,
	output logic [ROOT_W-1:0] out_root,
	output ctx_t              out_ctx
);

	typedef struct packed {
		logic [V_W-1:0]      rad;
		logic [SQ_REM_W-1:0] rem;
		logic [ROOT_W-1:0]   root;
	} sq_t;

	// Restoring square root steps: bring in two radicand bits, try root*4+1.
	function automatic sq_t sq_steps(sq_t a);
		sq_t r;
		logic [SQ_REM_W-1:0] trial;
		r = a;
		for (int i = 0; i < SQ_STEPS; i++) begin
			r.rem = {r.rem[SQ_REM_W-3:0], r.rad[V_W-1 -: 2]};
			r.rad = {r.rad[V_W-3:0], 2'b00};
			trial = SQ_REM_W'({r.root, 2'b01});
			if (r.rem >= trial) begin
				r.rem  = r.rem - trial;
				r.root = {r.root[ROOT_W-2:0], 1'b1};
			end else begin
				r.root = {r.root[ROOT_W-2:0], 1'b0};
			end
		end
		return r;
	endfunction

	logic valid_s [SQ_STAGES];
	sq_t  sq_s    [SQ_STAGES];
	ctx_t ctx_s   [SQ_STAGES];

	for (genvar st = 0; st < SQ_STAGES; st++) begin : g_stg
		sq_t  prev;
		ctx_t prev_ctx;
		logic prev_valid;

		// Each stage takes the previous stage, the first takes the inputs.
		if (st == 0) begin : g_first
			assign prev       = {in_rad, SQ_REM_W'(0), ROOT_W'(0)};
			assign prev_ctx   = in_ctx;
			assign prev_valid = in_valid;
		end else begin : g_next
			assign prev       = sq_s[st-1];
			assign prev_ctx   = ctx_s[st-1];
			assign prev_valid = valid_s[st-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[st] <= 1'b0;
			end else if (en) begin
				valid_s[st] <= prev_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s[st]  <= sq_steps(prev);
				ctx_s[st] <= prev_ctx;
			end
		end
	end

	assign out_valid = valid_s[SQ_STAGES-1];
	assign out_root  = sq_s[SQ_STAGES-1].root;
	assign out_ctx   = ctx_s[SQ_STAGES-1];

endmodule

// ----- rtl/core/rmsp_div.sv -----
// Pipelined unsigned restoring divider, four quotient bits per stage.
// Carries the item context alongside. Depends on rmsp_pkg.
module rmsp_div
	import rmsp_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_valid,
	input  logic [NUM_W-1:0] in_num,
	input  logic [DEN_W-1:0] in_den,
	input  ctx_t             in_ctx,
	output logic             out_valid,
	output logic [NUM_W-1:0] out_quo,
	output ctx_t             out_ctx
);

	typedef struct packed {
		logic [NUM_W-1:0]     nq;
		logic [DIV_REM_W-1:0] rem;
		logic [DEN_W-1:0]     den;
	} dv_t;

	// Shift one numerator bit into the remainder, subtract the divisor if it fits.
	function automatic dv_t div_steps(dv_t a);
		dv_t r;
		logic [DIV_REM_W-1:0] dext;
		r = a;
		dext = DIV_REM_W'(a.den);
		for (int i = 0; i < DIV_STEPS; i++) begin
			r.rem = {r.rem[DIV_REM_W-2:0], r.nq[NUM_W-1]};
			r.nq  = {r.nq[NUM_W-2:0], 1'b0};
			if (r.rem >= dext) begin
				r.rem   = r.rem - dext;
				r.nq[0] = 1'b1;
			end
		end
		return r;
	endfunction

	logic valid_s [DIV_STAGES];
	dv_t  dv_s    [DIV_STAGES];
	ctx_t ctx_s   [DIV_STAGES];

	for (genvar st = 0; st < DIV_STAGES; st++) begin : g_stg
		dv_t  prev;
		ctx_t prev_ctx;
		logic prev_valid;

		if (st == 0) begin : g_first
			assign prev       = {in_num, DIV_REM_W'(0), in_den};
			assign prev_ctx   = in_ctx;
			assign prev_valid = in_valid;
		end else begin : g_next
			assign prev       = dv_s[st-1];
			assign prev_ctx   = ctx_s[st-1];
			assign prev_valid = valid_s[st-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[st] <= 1'b0;
			end else if (en) begin
				valid_s[st] <= prev_valid;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[st]  <= div_steps(prev);
				ctx_s[st] <= prev_ctx;
			end
		end
	end

	assign out_valid = valid_s[DIV_STAGES-1];
	assign out_quo   = dv_s[DIV_STAGES-1].nq;
	assign out_ctx   = ctx_s[DIV_STAGES-1];

endmodule

// ----- rtl/core/rmsprop_weight_update.sv -----
// Top level of the RMSprop weight update block.
// Depends on rmsp_pkg, rmsp_sqrt and rmsp_div.
//
// Usage:
// - Input channel (in_valid/in_ready): cmd, entry_index, weight_in, gradient.
//   An update item reads and rewrites the squared-gradient average of its entry
//   and yields the new weight; a clear item empties the whole average store and
//   echoes weight_in.
// - Output channel (out_valid/out_ready): weight_out, index_out, saturated;
//   exactly one result item per input item, in order.
// - Configuration: cfg_we writes learning_rate (index 0) or decay (index 1).
// - One item is accepted per cycle unless a stall or a clearing pass holds
//   in_ready low; the whole pipeline advances together and holds while the
//   output register is full and out_ready is low, so a stall loses nothing.
// - The read-modify-write loop on the average memory (with forwarding from
//   the next stage) sets that rate.
// - After reset a clearing pass over all ENTRIES slots writes the store's epoch tags
//   while in_ready is low. A clear item normally just advances the epoch; every
//   255th clear wraps the epoch and triggers the same pass.
module rmsprop_weight_update
	import rmsp_pkg::*;
#(
	parameter int ENTRIES = 4096
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 cmd,
	input  logic [IDX_W-1:0]     entry_index,
	input  logic [DATA_W-1:0]    weight_in,
	input  logic [DATA_W-1:0]    gradient,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [DATA_W-1:0]    weight_out,
	output logic [IDX_W-1:0]     index_out,
	output logic                 saturated,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	localparam int SLOT_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	typedef struct packed {
		logic [TAG_W-1:0] tag;
		logic [V_W-1:0]   v;
	} ent_t;

	// Entry index reduced modulo the store depth by conditional subtraction.
	function automatic logic [IDX_W-1:0] idx_mod(logic [IDX_W-1:0] x);
		logic [IDX_W-1:0] r;
		r = x;
		for (int k = IDX_W - 1; k >= 0; k--) begin
			if ((longint'(ENTRIES) << k) < (longint'(1) << IDX_W)) begin
				if (r >= IDX_W'(longint'(ENTRIES) << k)) begin
					r = r - IDX_W'(longint'(ENTRIES) << k);
				end
			end
		end
		return r;
	endfunction

	logic [CFG_W-1:0]  lr_q, decay_q;
	logic [TAG_W-1:0]  epoch_q;
	logic              sweep_q;
	logic [SLOT_W-1:0] sweep_addr_q;
	logic              adv, in_fire, clr_fire;

	// Input side combinational values.
	logic              neg_in;
	logic [DATA_W-1:0] mag_in;
	logic [63:0]       sq_in;
	logic [SLOT_W-1:0] slot_in;
	ctx_t              ctx_in;

	// Stage 1: read data back, square ready.
	logic              valid_s1;
	ctx_t              ctx_s1;
	logic [V_W-1:0]    g2_s1;
	logic [SLOT_W-1:0] slot_s1;
	ent_t              rd_s1;

	// Stage 2: new average.
	logic              valid_s2;
	ctx_t              ctx_s2;
	logic [V_W-1:0]    v_s2;
	logic [SLOT_W-1:0] slot_s2;

	// Square root output and stage 3: numerator and denominator.
	logic              sq_valid;
	logic [ROOT_W-1:0] sq_root;
	ctx_t              sq_ctx;
	logic              valid_s3;
	ctx_t              ctx_s3;
	logic [NUM_W-1:0]  num_s3;
	logic [DEN_W-1:0]  den_s3;

	// Divider output and output register.
	logic              dv_valid;
	logic [NUM_W-1:0]  dv_quo;
	ctx_t              dv_ctx;
	logic              out_valid_q;
	logic [DATA_W-1:0] weight_out_q;
	logic [IDX_W-1:0]  index_out_q;
	logic              saturated_q;

	ent_t mem [ENTRIES];

	logic [V_W-1:0]  v_old, v_new;
	logic [64:0]     acc;
	logic [16:0]     one_minus;
	logic [DATA_W:0] qlim;
	logic            qsat;
	logic signed [DATA_W+1:0] q_full, res_full;
	logic [DATA_W-1:0] res_w;
	logic              res_sat;

	// Handshake: everything moves together when the output register can move.
	assign adv      = !out_valid_q || out_ready;
	assign in_ready = adv && !sweep_q;
	assign in_fire  = in_valid && in_ready;
	assign clr_fire = in_fire && (cmd_t'(cmd) == CMD_CLEAR);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lr_q    <= LR_RESET;
			decay_q <= DECAY_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LR:    lr_q    <= cfg_data;
				REG_DECAY: decay_q <= cfg_data;
			endcase
		end
	end

	// Epoch of valid entries and the tag clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			epoch_q      <= TAG_W'(1);
			sweep_q      <= 1'b1;
			sweep_addr_q <= '0;
		end else if (clr_fire) begin
			if (epoch_q == '1) begin
				epoch_q      <= TAG_W'(1);
				sweep_q      <= 1'b1;
				sweep_addr_q <= '0;
			end else begin
				epoch_q <= epoch_q + TAG_W'(1);
			end
		end else if (sweep_q) begin
			if (sweep_addr_q == SLOT_W'(ENTRIES - 1)) begin
				sweep_q <= 1'b0;
			end
			sweep_addr_q <= sweep_addr_q + SLOT_W'(1);
		end
	end

	// Input decode: magnitude, square and store slot.
	always_comb begin
		neg_in  = gradient[DATA_W-1];
		mag_in  = neg_in ? (DATA_W'(0) - gradient) : gradient;
		sq_in   = 64'(mag_in) * 64'(mag_in);
		slot_in = SLOT_W'(idx_mod(entry_index));
		ctx_in  = '{cmd: cmd_t'(cmd), idx: entry_index, weight: weight_in,
			neg: neg_in, mag: mag_in};
	end

	// Stage 1 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_fire;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s1  <= ctx_in;
			g2_s1   <= sq_in[63:16];
			slot_s1 <= slot_in;
		end
	end

	// Average memory: registered read at acceptance, write when stage 1 moves on.
	always_ff @(posedge clk) begin
		if (adv) begin
			rd_s1 <= mem[slot_in];
		end
		if (sweep_q) begin
			mem[sweep_addr_q] <= '0;
		end else if (adv && valid_s1 && ctx_s1.cmd == CMD_UPDATE) begin
			mem[slot_s1] <= '{tag: epoch_q, v: v_new};
		end
	end

	// New average, with the previous item's result forwarded on a slot match.
	always_comb begin
		if (valid_s2 && ctx_s2.cmd == CMD_UPDATE && slot_s2 == slot_s1) begin
			v_old = v_s2;
		end else if (rd_s1.tag == epoch_q) begin
			v_old = rd_s1.v;
		end else begin
			v_old = '0;
		end
		one_minus = 17'h10000 - 17'(decay_q);
		acc       = 65'(decay_q) * 65'(v_old) + 65'(one_minus) * 65'(g2_s1);
		v_new     = acc[V_W+15:16];
	end

	// Stage 2 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s2  <= ctx_s1;
			v_s2    <= v_new;
			slot_s2 <= slot_s1;
		end
	end

	rmsp_sqrt u_sqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s2),
		.in_rad    (v_s2),
		.in_ctx    (ctx_s2),
		.out_valid (sq_valid),
		.out_root  (sq_root),
		.out_ctx   (sq_ctx)
	);

	// Stage 3: scaled gradient magnitude and denominator root plus epsilon.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			ctx_s3 <= sq_ctx;
			num_s3 <= NUM_W'(lr_q) * NUM_W'(sq_ctx.mag);
			den_s3 <= DEN_W'(sq_root) + DEN_W'(1);
		end
	end

	rmsp_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (adv),
		.in_valid  (valid_s3),
		.in_num    (num_s3),
		.in_den    (den_s3),
		.in_ctx    (ctx_s3),
		.out_valid (dv_valid),
		.out_quo   (dv_quo),
		.out_ctx   (dv_ctx)
	);

	// Signed step with clamping, then the weight subtraction with clamping.
	always_comb begin
		qsat = 1'b0;
		if (dv_ctx.neg) begin
			if (dv_quo > NUM_W'(33'h080000000)) begin
				qlim = 33'h080000000;
				qsat = 1'b1;
			end else begin
				qlim = dv_quo[DATA_W:0];
			end
			q_full = (DATA_W+2)'(0) - $signed((DATA_W+2)'(qlim));
		end else begin
			if (dv_quo > NUM_W'(33'h07FFFFFFF)) begin
				qlim = 33'h07FFFFFFF;
				qsat = 1'b1;
			end else begin
				qlim = dv_quo[DATA_W:0];
			end
			q_full = $signed((DATA_W+2)'(qlim));
		end
		res_full = $signed({{2{dv_ctx.weight[DATA_W-1]}}, dv_ctx.weight}) - q_full;
		res_sat  = qsat;
		if (res_full > $signed((DATA_W+2)'(34'h07FFFFFFF))) begin
			res_w   = 32'h7FFFFFFF;
			res_sat = 1'b1;
		end else if (res_full < $signed(34'h380000000)) begin
			res_w   = 32'h80000000;
			res_sat = 1'b1;
		end else begin
			res_w = res_full[DATA_W-1:0];
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			index_out_q <= dv_ctx.idx;
			if (dv_ctx.cmd == CMD_CLEAR) begin
				weight_out_q <= dv_ctx.weight;
				saturated_q  <= 1'b0;
			end else begin
				weight_out_q <= res_w;
				saturated_q  <= res_sat;
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign weight_out = weight_out_q;
	assign index_out  = index_out_q;
	assign saturated  = saturated_q;

endmodule
